@@ rtl/sync_length_checksum_deframer_macros.svh @@
// Assertion macros of the deframer RTL.
`ifndef SYNC_LENGTH_CHECKSUM_DEFRAMER_MACROS_SVH
`define SYNC_LENGTH_CHECKSUM_DEFRAMER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SLCD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SLCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/slcd_pkg.sv @@
// Package with types and constants of the sync, length and checksum deframer.
package slcd_pkg;

    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;
    localparam int BYTE_W   = 8;
    localparam int INDEX_W  = 4;
    localparam int TICK_W   = 16;

    localparam logic [BYTE_W-1:0] SYNC_VALUE_RST   = 8'h15;
    localparam logic [BYTE_W-1:0] FRAME_LENGTH_RST = 8'h07;
    localparam logic [TICK_W-1:0] TIMEOUT_RST      = 16'd3;
    localparam logic [BYTE_W-1:0] MIN_LENGTH       = 8'd2;
    localparam logic [TICK_W-1:0] IDLE_MAX         = 16'hFFFF;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [1:0] {
        REG_SYNC_VALUE    = 2'd0,
        REG_FRAME_LENGTH  = 2'd1,
        REG_TIMEOUT_TICKS = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_value;
        logic [BYTE_W-1:0] frame_length;
        logic [TICK_W-1:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic               store_valid;
        logic [INDEX_W-1:0] store_index;
        logic [BYTE_W-1:0]  store_data;
        logic               packet_good;
        logic               frame_abort;
        logic               in_frame;
    } result_t;

endpackage

@@ rtl/slcd_if.sv @@
// Handshake interfaces for input items and result items of the deframer.
interface slcd_item_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] rx_byte;

    modport source (output valid, output operation, output rx_byte, input ready);
    modport sink (input valid, input operation, input rx_byte, output ready);
endinterface

interface slcd_result_if;
    logic       valid;
    logic       ready;
    logic       store_valid;
    logic [3:0] store_index;
    logic [7:0] store_data;
    logic       packet_good;
    logic       frame_abort;
    logic       in_frame;

    modport source (output valid, output store_valid, output store_index, output store_data,
                    output packet_good, output frame_abort, output in_frame, input ready);
    modport sink (input valid, input store_valid, input store_index, input store_data,
                  input packet_good, input frame_abort, input in_frame, output ready);
endinterface

@@ rtl/slcd_cfg_regs.sv @@
// APB configuration registers of the deframer.
module slcd_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [slcd_pkg::ADDR_W-1:0] paddr,
    input  logic [slcd_pkg::DATA_W-1:0] pwdata,
    output logic [slcd_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output slcd_pkg::cfg_t              cfg
);
    import slcd_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t reg_idx;
    logic     wr_en;

    assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_SYNC_VALUE:    cfg_next.sync_value    = pwdata[BYTE_W-1:0];
                REG_FRAME_LENGTH:  cfg_next.frame_length  = pwdata[BYTE_W-1:0];
                REG_TIMEOUT_TICKS: cfg_next.timeout_ticks = pwdata[TICK_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_SYNC_VALUE:    prdata = DATA_W'(cfg_reg.sync_value);
            REG_FRAME_LENGTH:  prdata = DATA_W'(cfg_reg.frame_length);
            REG_TIMEOUT_TICKS: prdata = DATA_W'(cfg_reg.timeout_ticks);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_value    <= SYNC_VALUE_RST;
            cfg_reg.frame_length  <= FRAME_LENGTH_RST;
            cfg_reg.timeout_ticks <= TIMEOUT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ rtl/sync_length_checksum_deframer.sv @@
// Top level of the sync, length and checksum deframer.
// A result item is registered and appears in the cycle after its input item is accepted.
// One item per cycle while the result register is empty or drained; the frame state register updates in one pass.
// An input item is taken whenever the result register is empty or being drained.
// Reset clears the frame state, the result register and loads register defaults.
`include "sync_length_checksum_deframer_macros.svh"

module sync_length_checksum_deframer #(
    parameter int BUFFER_DEPTH = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    slcd_item_if.sink                   item_in,
    slcd_result_if.source               item_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [slcd_pkg::ADDR_W-1:0] paddr,
    input  logic [slcd_pkg::DATA_W-1:0] pwdata,
    output logic [slcd_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import slcd_pkg::*;

    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

    cfg_t cfg;

    logic              synced_reg, synced_next;
    logic              length_seen_reg, length_seen_next;
    logic              length_matches_reg, length_matches_next;
    logic [BYTE_W-1:0] bytes_left_reg, bytes_left_next;
    logic [BYTE_W-1:0] running_sum_reg, running_sum_next;
    logic [CNT_W-1:0]  stored_count_reg, stored_count_next;
    logic [TICK_W-1:0] idle_count_reg, idle_count_next;
    logic              out_valid_reg, out_valid_next;
    result_t           result_reg, result_next;

    logic              accept;
    logic [TICK_W-1:0] idle_inc;
    logic [BYTE_W-1:0] sum_add;
    logic [BYTE_W-1:0] left_dec;
    logic [BYTE_W-1:0] count_wide;
    logic              hunt;

    slcd_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign item_in.ready = !out_valid_reg || item_out.ready;
    assign accept        = item_in.valid && item_in.ready;

    assign idle_inc   = (idle_count_reg == IDLE_MAX) ? idle_count_reg
                                                     : idle_count_reg + TICK_W'(1);
    assign sum_add    = running_sum_reg + item_in.rx_byte;
    assign left_dec   = bytes_left_reg - BYTE_W'(1);
    assign count_wide = BYTE_W'(stored_count_reg);

    always_comb
    begin
        hunt                = 1'b0;
        synced_next         = synced_reg;
        length_seen_next    = length_seen_reg;
        length_matches_next = length_matches_reg;
        bytes_left_next     = bytes_left_reg;
        running_sum_next    = running_sum_reg;
        stored_count_next   = stored_count_reg;
        idle_count_next     = idle_count_reg;
        result_next         = '0;

        if (item_in.operation == OP_TICK)
        begin
            if (synced_reg)
            begin
                idle_count_next = idle_inc;
                if (idle_inc > cfg.timeout_ticks)
                begin
                    hunt                    = 1'b1;
                    result_next.frame_abort = 1'b1;
                end
            end
        end
        else
        begin
            idle_count_next = '0;
            if (!synced_reg)
            begin
                if (item_in.rx_byte == cfg.sync_value)
                begin
                    synced_next = 1'b1;
                end
            end
            else if (!length_seen_reg)
            begin
                length_seen_next  = 1'b1;
                stored_count_next = '0;
                if (item_in.rx_byte < MIN_LENGTH)
                begin
                    hunt = 1'b1;
                end
                else
                begin
                    length_matches_next = (item_in.rx_byte == cfg.frame_length);
                    running_sum_next    = item_in.rx_byte;
                    bytes_left_next     = item_in.rx_byte - BYTE_W'(1);
                end
            end
            else
            begin
                running_sum_next = sum_add;
                bytes_left_next  = left_dec;
                if (length_matches_reg)
                begin
                    if (left_dec == '0)
                    begin
                        result_next.packet_good = (sum_add == '0);
                        hunt                    = 1'b1;
                    end
                    else if (stored_count_reg < CNT_W'(BUFFER_DEPTH))
                    begin
                        result_next.store_valid = 1'b1;
                        result_next.store_index = count_wide[INDEX_W-1:0];
                        result_next.store_data  = item_in.rx_byte;
                        stored_count_next       = stored_count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        hunt                    = 1'b1;
                        result_next.frame_abort = 1'b1;
                    end
                end
                else if (left_dec == '0)
                begin
                    hunt = 1'b1;
                end
            end
        end

        if (hunt)
        begin
            synced_next         = 1'b0;
            length_seen_next    = 1'b0;
            length_matches_next = 1'b0;
            bytes_left_next     = '0;
            idle_count_next     = '0;
        end

        result_next.in_frame = synced_next;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (item_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            synced_reg         <= 1'b0;
            length_seen_reg    <= 1'b0;
            length_matches_reg <= 1'b0;
            bytes_left_reg     <= '0;
            running_sum_reg    <= '0;
            stored_count_reg   <= '0;
            idle_count_reg     <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                synced_reg         <= synced_next;
                length_seen_reg    <= length_seen_next;
                length_matches_reg <= length_matches_next;
                bytes_left_reg     <= bytes_left_next;
                running_sum_reg    <= running_sum_next;
                stored_count_reg   <= stored_count_next;
                idle_count_reg     <= idle_count_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_reg <= '0;
        end
        else if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign item_out.valid       = out_valid_reg;
    assign item_out.store_valid = result_reg.store_valid;
    assign item_out.store_index = result_reg.store_index;
    assign item_out.store_data  = result_reg.store_data;
    assign item_out.packet_good = result_reg.packet_good;
    assign item_out.frame_abort = result_reg.frame_abort;
    assign item_out.in_frame    = result_reg.in_frame;

    `SLCD_ASSERT_NOW(a_store_in_frame, clk, rst_n, out_valid_reg && result_reg.store_valid, result_reg.in_frame, "Stored byte reported outside a frame.")
    `SLCD_ASSERT_NOW(a_end_leaves_frame, clk, rst_n, out_valid_reg && (result_reg.packet_good || result_reg.frame_abort), !result_reg.in_frame, "Frame end reported while still in a frame.")
    `SLCD_ASSERT_NOW(a_length_needs_sync, clk, rst_n, length_seen_reg, synced_reg, "Length seen without sync.")
    `SLCD_ASSERT_NEXT(a_count_bound, clk, rst_n, accept, stored_count_reg <= CNT_W'(BUFFER_DEPTH), "Stored count beyond buffer depth.")

endmodule
